### rtl/paed_pkg.sv
package paed_pkg;

   // stream layout
   localparam int CHANNELS     = 16;
   localparam int FRAME_BYTES  = 40;
   localparam int FOOTER_BYTES = 16;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [7:0]  HEADER_BYTE    = 8'hAA;
   localparam logic [7:0]  FOOTER_BYTE    = 8'hBB;
   localparam logic [15:0] TRAILER_MID    = 16'hFEFE;
   localparam logic [15:0] TRAILER_FINAL  = 16'hAEAE;
   localparam logic [63:0] MAP_RESET      = 64'hFEDCBA9876543210;

   // byte positions inside a section
   localparam logic [5:0] MARK_LAST       = 6'd3;
   localparam logic [5:0] WORD_BYTES_END  = 6'd32;
   localparam logic [5:0] TRAILER_HI_POS  = 6'd38;
   localparam logic [5:0] FRAME_LAST      = 6'(FRAME_BYTES - 1);
   localparam logic [31:0] FRAME_LEN      = 32'(FRAME_BYTES);
   localparam logic [31:0] TWO_FRAME_LEN  = 32'(2 * FRAME_BYTES);
   localparam logic [3:0] VALUE_LAST      = 4'(CHANNELS - 1);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_FOOT_OR_HEAD,
      PH_FOOT_SKIP
   } phase_type;

   // one finished frame handed from parser to output side
   typedef struct packed {
      logic [CHANNELS-1:0][15:0] words;
      logic [26:0]               frame_index;
      logic [31:0]               event_index;
      logic                      final_frame;
      logic                      trailer_ok;
      logic                      header_ok;
   } frame_type;

endpackage

### rtl/pixel_adc_event_deframer.sv
// Pixel ADC event deframer.
// req_* carries one raw stream byte per item; an item is taken at a clock edge
// with req_valid high and req_stall low. rsp_* carries one ADC value per item,
// sixteen per 40-byte frame, in value order, with rsp_last on the sixteenth.
// csr_wr_en/csr_wr_data load the 64-bit channel map; write it only while idle.
// Throughput: one byte per cycle at the input while req_stall is low. A frame
// is popped from the queue, then its values leave one per cycle while the
// output is not stalled. The frame's last byte pushes it into the queue; with
// the output idle, it is then popped and its first value loaded for output.
// A two-frame queue sits between the parser and the output sequencer; the
// input is stalled only while both slots are taken, which happens only when
// the receiver holds rsp_stall long enough.
// A stalled result stays unchanged in the output register.
// Reset (synchronous): parser waits for a header, event and frame counters
// clear, queue empties, channel map returns to identity.
module pixel_adc_event_deframer #(
   parameter int FOOTER_BYTES = paed_pkg::FOOTER_BYTES,
   parameter int QUEUE_DEPTH  = paed_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_channel,
   output logic [15:0] rsp_adc_value,
   output logic [26:0] rsp_frame_index,
   output logic [31:0] rsp_event_index,
   output logic        rsp_final_frame,
   output logic        rsp_trailer_ok,
   output logic        rsp_header_ok,
   output logic        rsp_last
);

   logic                push;
   paed_pkg::frame_type push_frame;
   logic                queue_full;
   logic                pop;
   logic                head_valid;
   paed_pkg::frame_type head_frame;

   // byte parser
   paed_front #(
      .FOOTER_BYTES (FOOTER_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_frame    (push_frame)
   );

   // frame queue
   paed_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_frame (head_frame)
   );

   // value sequencer and output register
   paed_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .head_valid      (head_valid),
      .head_frame      (head_frame),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_channel     (rsp_channel),
      .rsp_adc_value   (rsp_adc_value),
      .rsp_frame_index (rsp_frame_index),
      .rsp_event_index (rsp_event_index),
      .rsp_final_frame (rsp_final_frame),
      .rsp_trailer_ok  (rsp_trailer_ok),
      .rsp_header_ok   (rsp_header_ok),
      .rsp_last        (rsp_last)
   );

endmodule

### rtl/paed_front.sv
module paed_front #(
   parameter int FOOTER_BYTES = paed_pkg::FOOTER_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                queue_full,
   output logic                push,
   output paed_pkg::frame_type push_frame
);

   localparam logic [5:0] FootSkipLast = 6'(FOOTER_BYTES - 5);

   paed_pkg::phase_type phase_ff, phase_in;
   logic [5:0]  sc_ff, sc_in;
   logic        hgood_ff, hgood_in;
   logic        fmatch_ff, fmatch_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] left_ff, left_in;
   logic [26:0] fc_ff, fc_in;
   logic [31:0] ec_ff, ec_in;
   logic        final_ff, final_in;
   logic [7:0]  trail_hi_ff, trail_hi_in;
   logic [paed_pkg::CHANNELS-1:0][15:0] words_ff, words_in;

   logic        accept;
   logic [5:0]  sc_inc;
   logic [31:0] len_new;
   logic [31:0] left_dec;
   logic        left_zero;
   logic        fmatch_new;
   logic        hdr_byte_ok;
   logic        active;
   logic        frame_done;
   logic [15:0] trailer;

   // handshake: hold the byte while the queue has no room
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // shared decode of the current byte
   assign sc_inc      = sc_ff + 6'd1;
   assign len_new     = len_ff | (32'(req_data_byte) << {sc_ff[1:0], 3'b000});
   assign left_dec    = left_ff - 32'd1;
   assign left_zero   = (left_dec == 32'd0);
   assign hdr_byte_ok = (req_data_byte == paed_pkg::HEADER_BYTE);
   assign fmatch_new  = fmatch_ff && (req_data_byte == paed_pkg::FOOTER_BYTE);
   // a frame starts only while a whole frame is left in the payload
   assign active      = (sc_ff != 6'd0) || (left_ff >= paed_pkg::FRAME_LEN);
   assign frame_done  = active && (sc_ff == paed_pkg::FRAME_LAST);
   assign trailer     = {trail_hi_ff, req_data_byte};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            paed_pkg::PH_LENGTH: begin
               if (sc_ff == paed_pkg::MARK_LAST) begin
                  phase_in = (len_new == 32'd0) ? paed_pkg::PH_FOOT_OR_HEAD
                                                : paed_pkg::PH_PAYLOAD;
               end
            end
            paed_pkg::PH_PAYLOAD: begin
               if (left_zero) begin
                  phase_in = paed_pkg::PH_FOOT_OR_HEAD;
               end
            end
            paed_pkg::PH_FOOT_OR_HEAD: begin
               if (sc_ff == paed_pkg::MARK_LAST) begin
                  if (fmatch_new) begin
                     phase_in = (FOOTER_BYTES > 4) ? paed_pkg::PH_FOOT_SKIP
                                                   : paed_pkg::PH_HEADER;
                  end else begin
                     phase_in = paed_pkg::PH_LENGTH;
                  end
               end
            end
            paed_pkg::PH_FOOT_SKIP: begin
               if (sc_ff == FootSkipLast) begin
                  phase_in = paed_pkg::PH_HEADER;
               end
            end
            default: begin
               if (sc_ff == paed_pkg::MARK_LAST) begin
                  phase_in = paed_pkg::PH_LENGTH;
               end
            end
         endcase
      end
   end

   // counters, flags and frame capture
   always_comb begin
      sc_in       = sc_ff;
      hgood_in    = hgood_ff;
      fmatch_in   = fmatch_ff;
      len_in      = len_ff;
      left_in     = left_ff;
      fc_in       = fc_ff;
      ec_in       = ec_ff;
      final_in    = final_ff;
      trail_hi_in = trail_hi_ff;
      words_in    = words_ff;
      if (accept) begin
         case (phase_ff)
            paed_pkg::PH_LENGTH: begin
               len_in = len_new;
               sc_in  = sc_inc;
               if (sc_ff == paed_pkg::MARK_LAST) begin
                  sc_in   = 6'd0;
                  left_in = len_new;
                  fc_in   = 27'd0;
                  if (len_new == 32'd0) begin
                     ec_in     = ec_ff + 32'd1;
                     hgood_in  = 1'b1;
                     fmatch_in = 1'b1;
                  end
               end
            end
            paed_pkg::PH_PAYLOAD: begin
               if (active) begin
                  if (sc_ff == 6'd0) begin
                     final_in = (left_ff < paed_pkg::TWO_FRAME_LEN);
                  end
                  if (sc_ff < paed_pkg::WORD_BYTES_END) begin
                     if (sc_ff[0]) begin
                        words_in[sc_ff[4:1]][15:8] = req_data_byte;
                     end else begin
                        words_in[sc_ff[4:1]][7:0] = req_data_byte;
                     end
                  end
                  if (sc_ff == paed_pkg::TRAILER_HI_POS) begin
                     trail_hi_in = req_data_byte;
                  end
                  if (frame_done) begin
                     sc_in = 6'd0;
                     fc_in = fc_ff + 27'd1;
                  end else begin
                     sc_in = sc_inc;
                  end
               end
               left_in = left_dec;
               // end of event
               if (left_zero) begin
                  ec_in     = ec_ff + 32'd1;
                  sc_in     = 6'd0;
                  hgood_in  = 1'b1;
                  fmatch_in = 1'b1;
                  fc_in     = 27'd0;
               end
            end
            paed_pkg::PH_FOOT_OR_HEAD: begin
               hgood_in  = hgood_ff && hdr_byte_ok;
               fmatch_in = fmatch_new;
               sc_in     = sc_inc;
               if (sc_ff == paed_pkg::MARK_LAST) begin
                  sc_in = 6'd0;
                  if (fmatch_new) begin
                     hgood_in = 1'b1;
                  end else begin
                     len_in = 32'd0;
                  end
               end
            end
            paed_pkg::PH_FOOT_SKIP: begin
               sc_in = sc_inc;
               if (sc_ff == FootSkipLast) begin
                  sc_in = 6'd0;
               end
            end
            default: begin
               hgood_in = hgood_ff && hdr_byte_ok;
               sc_in    = sc_inc;
               if (sc_ff == paed_pkg::MARK_LAST) begin
                  sc_in  = 6'd0;
                  len_in = 32'd0;
               end
            end
         endcase
      end
   end

   // hand a finished frame to the queue
   assign push = accept && (phase_ff == paed_pkg::PH_PAYLOAD) && frame_done;

   always_comb begin
      push_frame.words       = words_ff;
      push_frame.frame_index = fc_ff;
      push_frame.event_index = ec_ff;
      push_frame.final_frame = final_ff;
      push_frame.trailer_ok  = final_ff ? (trailer == paed_pkg::TRAILER_FINAL)
                                        : (trailer == paed_pkg::TRAILER_MID);
      push_frame.header_ok   = hgood_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= paed_pkg::PH_HEADER;
         sc_ff       <= 6'd0;
         hgood_ff    <= 1'b1;
         fmatch_ff   <= 1'b1;
         len_ff      <= 32'd0;
         left_ff     <= 32'd0;
         fc_ff       <= 27'd0;
         ec_ff       <= 32'd0;
         final_ff    <= 1'b0;
         trail_hi_ff <= 8'd0;
      end else begin
         phase_ff    <= phase_in;
         sc_ff       <= sc_in;
         hgood_ff    <= hgood_in;
         fmatch_ff   <= fmatch_in;
         len_ff      <= len_in;
         left_ff     <= left_in;
         fc_ff       <= fc_in;
         ec_ff       <= ec_in;
         final_ff    <= final_in;
         trail_hi_ff <= trail_hi_in;
      end
   end

   // frame word buffer
   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

endmodule

### rtl/paed_fifo.sv
module paed_fifo #(
   parameter int QUEUE_DEPTH = paed_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  paed_pkg::frame_type push_frame,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output paed_pkg::frame_type head_frame
);

   localparam int PtrBits   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CountBits-1:0] DepthCount = CountBits'(QUEUE_DEPTH);
   localparam logic [PtrBits-1:0]   PtrLast    = PtrBits'(QUEUE_DEPTH - 1);

   paed_pkg::frame_type slots_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full       = (count_ff == DepthCount);
   assign head_valid = (count_ff != '0);
   assign head_frame = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_frame;
      end
   end

   // the parser must never offer a frame to a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("frame offered to a full queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCount)
      else $error("queue fill beyond depth");

endmodule

### rtl/paed_back.sv
module paed_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [63:0]         csr_wr_data,
   input  logic                head_valid,
   input  paed_pkg::frame_type head_frame,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_channel,
   output logic [15:0]         rsp_adc_value,
   output logic [26:0]         rsp_frame_index,
   output logic [31:0]         rsp_event_index,
   output logic                rsp_final_frame,
   output logic                rsp_trailer_ok,
   output logic                rsp_header_ok,
   output logic                rsp_last
);

   logic [63:0]         map_ff;
   logic                busy_ff, busy_in;
   logic [3:0]          idx_ff, idx_in;
   paed_pkg::frame_type cur_ff;
   logic                valid_ff, valid_in;
   logic [3:0]          channel_ff;
   logic [15:0]         adc_ff;
   logic [26:0]         frame_ff;
   logic [31:0]         event_ff;
   logic                final_ff;
   logic                tok_ff;
   logic                hok_ff;
   logic                last_ff;

   logic        out_free;
   logic        out_load;
   logic [15:0] value;

   assign out_free = !valid_ff || !rsp_stall;
   assign out_load = busy_ff && out_free;
   assign pop      = !busy_ff && head_valid;

   // bit transpose: bit 15-k of value idx is bit idx of word k
   always_comb begin
      for (int k = 0; k < paed_pkg::CHANNELS; k++) begin
         value[15-k] = cur_ff.words[k][idx_ff];
      end
   end

   // value sequencer
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = 4'd0;
      end else if (out_load) begin
         idx_in = idx_ff + 4'd1;
         if (idx_ff == paed_pkg::VALUE_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   // output register valid
   always_comb begin
      valid_in = valid_ff;
      if (out_load) begin
         valid_in = 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff   <= paed_pkg::MAP_RESET;
         busy_ff  <= 1'b0;
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            map_ff <= csr_wr_data;
         end
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // frame in work and result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_frame;
      end
      if (out_load) begin
         channel_ff <= map_ff[{idx_ff, 2'b00} +: 4];
         adc_ff     <= value;
         frame_ff   <= cur_ff.frame_index;
         event_ff   <= cur_ff.event_index;
         final_ff   <= cur_ff.final_frame;
         tok_ff     <= cur_ff.trailer_ok;
         hok_ff     <= cur_ff.header_ok;
         last_ff    <= (idx_ff == paed_pkg::VALUE_LAST);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_channel     = channel_ff;
   assign rsp_adc_value   = adc_ff;
   assign rsp_frame_index = frame_ff;
   assign rsp_event_index = event_ff;
   assign rsp_final_frame = final_ff;
   assign rsp_trailer_ok  = tok_ff;
   assign rsp_header_ok   = hok_ff;
   assign rsp_last        = last_ff;

   // sixteenth value releases the frame
   a_frame_release: assert property (@(posedge clock) disable iff (reset)
      (out_load && idx_ff == paed_pkg::VALUE_LAST) |=> !busy_ff)
      else $error("frame still busy after its last value");

   // a freshly taken frame starts at value zero
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      pop |=> (busy_ff && idx_ff == 4'd0))
      else $error("new frame did not start at value zero");

endmodule
